>>> src/plt_pkg.sv
package plt_pkg;

   localparam int MAX_PEERS = 64;
   localparam int AW        = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
   localparam int CW        = $clog2(MAX_PEERS + 1);
   localparam int TALLY_W   = 7;
   localparam int CAP_W     = 7;

   localparam logic [9:0] US_PER_MS = 10'd1000;

   localparam logic [1:0] REG_HB_TIMEOUT   = 2'd0;
   localparam logic [1:0] REG_DEAD_TIMEOUT = 2'd1;
   localparam logic [1:0] REG_CAPACITY     = 2'd2;

   typedef enum logic [2:0] {
      FN_ADD       = 3'd0,
      FN_REMOVE    = 3'd1,
      FN_HEARTBEAT = 3'd2,
      FN_SET_STATE = 3'd3,
      FN_SWEEP     = 3'd4,
      FN_LOOKUP    = 3'd5,
      FN_COUNT     = 3'd6,
      FN_LIST      = 3'd7
   } func_type;

   typedef enum logic [2:0] {
      ST_UNKNOWN     = 3'd0,
      ST_DISCOVERING = 3'd1,
      ST_JOINING     = 3'd2,
      ST_ACTIVE      = 3'd3,
      ST_SUSPECTED   = 3'd4,
      ST_BYZANTINE   = 3'd5,
      ST_LEAVING     = 3'd6,
      ST_DEAD        = 3'd7
   } peer_state_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_NOT_FOUND = 2'd1,
      STAT_DUPLICATE = 2'd2,
      STAT_FULL      = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_PREP,
      S_RD,
      S_CHK,
      S_RDLAST,
      S_MOVE,
      S_EMIT
   } fsm_type;

   typedef struct packed {
      logic [31:0] id;
      logic [2:0]  state;
      logic [15:0] port;
      logic [63:0] last_seen;
      logic [63:0] joined;
      logic [31:0] missed;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      func_type     func;
      logic [31:0]  peer_id;
      logic [15:0]  peer_port;
      logic [2:0]   target_state;
      logic [63:0]  now_us;
      logic [6:0]   list_limit;
   } req_type;

   typedef struct packed {
      status_type   status;
      logic [31:0]  found_id;
      logic [2:0]   peer_state;
      logic [15:0]  found_port;
      logic [31:0]  missed_count;
      logic [63:0]  last_seen_us;
      logic [63:0]  joined_us;
      logic [TALLY_W-1:0] tally;
      logic         last;
   } rsp_type;

   typedef struct packed {
      logic [31:0]      hb_ms;
      logic [31:0]      dead_ms;
      logic [CAP_W-1:0] cap;
   } cfg_type;

   typedef struct packed {
      logic               we;
      logic [AW-1:0]      waddr;
      entry_type          wdata;
      logic [AW-1:0]      raddr;
   } ram_req_type;

   typedef struct packed {
      logic [CW-1:0] count;
   } ctrl_stat_type;

endpackage

>>> src/plt_ram.sv
module plt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> src/plt_csr.sv
module plt_csr (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [3:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready,
   output plt_pkg::cfg_type  cfg
);
   import plt_pkg::*;

   logic [31:0]      hb_ff, hb_in;
   logic [31:0]      dead_ff, dead_in;
   logic [CAP_W-1:0] cap_ff, cap_in;
   logic             wr;

   assign wr     = psel & penable & pwrite;
   assign pready = 1'b1;

   always_comb begin
      hb_in   = hb_ff;
      dead_in = dead_ff;
      cap_in  = cap_ff;
      if (wr) begin
         case (paddr[3:2])
            REG_HB_TIMEOUT:   hb_in   = pwdata;
            REG_DEAD_TIMEOUT: dead_in = pwdata;
            REG_CAPACITY:     cap_in  = pwdata[CAP_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_HB_TIMEOUT:   prdata = hb_ff;
         REG_DEAD_TIMEOUT: prdata = dead_ff;
         REG_CAPACITY:     prdata = {{(32-CAP_W){1'b0}}, cap_ff};
         default:          prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hb_ff   <= 32'd1000;
         dead_ff <= 32'd5000;
         cap_ff  <= CAP_W'(64);
      end else begin
         hb_ff   <= hb_in;
         dead_ff <= dead_in;
         cap_ff  <= cap_in;
      end
   end

   assign cfg = '{hb_ms: hb_ff, dead_ms: dead_ff, cap: cap_ff};

endmodule

>>> src/plt_ctrl.sv
module plt_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  plt_pkg::req_type       req,
   input  plt_pkg::cfg_type       cfg,
   output plt_pkg::ram_req_type   ram,
   input  plt_pkg::entry_type     rd,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output plt_pkg::rsp_type       rsp,
   output plt_pkg::ctrl_stat_type stat
);
   import plt_pkg::*;

   fsm_type            state_ff, state_in;
   req_type            req_ff, req_in;
   logic [CW-1:0]      idx_ff, idx_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [AW-1:0]      slot_ff, slot_in;
   logic [TALLY_W-1:0] tally_ff, tally_in;
   logic [TALLY_W-1:0] n_ff, n_in;
   logic               list2_ff, list2_in;
   logic [63:0]        hb_us_ff, hb_us_in;
   logic [63:0]        dead_us_ff, dead_us_in;
   rsp_type            pend_ff, pend_in;
   rsp_type            rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic [41:0]        hb_prod, dead_prod;
   logic [CW-1:0]      cnt_dec;
   logic               scan_end, full, match, is_active, out_free;
   logic [63:0]        elapsed;
   entry_type          swept;
   logic               died;
   rsp_type            zero_rsp;

   assign hb_prod   = 42'(cfg.hb_ms) * 42'(US_PER_MS);
   assign dead_prod = 42'(cfg.dead_ms) * 42'(US_PER_MS);
   assign cnt_dec   = count_ff - CW'(1);
   assign full      = (CAP_W'(count_ff) >= cfg.cap) || (count_ff >= CW'(MAX_PEERS));
   assign match     = (rd.id == req_ff.peer_id);
   assign is_active = (rd.state == ST_ACTIVE);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign scan_end  = (idx_ff >= count_ff) ||
                      (req_ff.func == FN_LIST && !list2_ff && tally_ff >= req_ff.list_limit);

   always_comb begin
      zero_rsp        = '0;
      zero_rsp.status = STAT_OK;
      zero_rsp.last   = 1'b1;
   end

   // aging of one entry
   always_comb begin
      elapsed = (req_ff.now_us > rd.last_seen) ? req_ff.now_us - rd.last_seen : 64'd0;
      swept   = rd;
      died    = 1'b0;
      if (rd.state == ST_ACTIVE && elapsed > hb_us_ff) begin
         if (rd.missed != 32'hFFFF_FFFF) begin
            swept.missed = rd.missed + 32'd1;
         end
         swept.state = ST_SUSPECTED;
      end
      if ((swept.state == ST_SUSPECTED || swept.state == ST_JOINING) && elapsed > dead_us_ff) begin
         swept.state = ST_DEAD;
         died        = 1'b1;
      end
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      idx_in       = idx_ff;
      count_in     = count_ff;
      slot_in      = slot_ff;
      tally_in     = tally_ff;
      n_in         = n_ff;
      list2_in     = list2_ff;
      hb_us_in     = hb_us_ff;
      dead_us_in   = dead_us_ff;
      pend_in      = pend_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      ram.we       = 1'b0;
      ram.waddr    = idx_ff[AW-1:0];
      ram.wdata    = rd;
      ram.raddr    = idx_ff[AW-1:0];

      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               req_in   = req;
               idx_in   = '0;
               tally_in = '0;
               list2_in = 1'b0;
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            hb_us_in   = 64'(hb_prod);
            dead_us_in = 64'(dead_prod);
            state_in   = S_RD;
         end
         S_RD: begin
            if (scan_end) begin
               pend_in  = zero_rsp;
               state_in = S_EMIT;
               case (req_ff.func)
                  FN_ADD: begin
                     if (full) begin
                        pend_in.status = STAT_FULL;
                     end else begin
                        ram.we    = 1'b1;
                        ram.waddr = count_ff[AW-1:0];
                        ram.wdata = '{id: req_ff.peer_id, state: ST_JOINING,
                                      port: req_ff.peer_port, last_seen: req_ff.now_us,
                                      joined: req_ff.now_us, missed: 32'd0};
                        count_in  = count_ff + CW'(1);
                     end
                  end
                  FN_REMOVE, FN_HEARTBEAT, FN_SET_STATE, FN_LOOKUP: begin
                     pend_in.status = STAT_NOT_FOUND;
                  end
                  FN_SWEEP, FN_COUNT: begin
                     pend_in.tally = tally_ff;
                  end
                  FN_LIST: begin
                     if (!list2_ff && tally_ff != '0) begin
                        n_in     = tally_ff;
                        tally_in = '0;
                        idx_in   = '0;
                        list2_in = 1'b1;
                        state_in = S_RD;
                     end else if (list2_ff) begin
                        state_in = S_IDLE;
                     end
                  end
                  default: ;
               endcase
            end else begin
               state_in = S_CHK;
            end
         end
         S_CHK: begin
            idx_in   = idx_ff + CW'(1);
            state_in = S_RD;
            pend_in  = zero_rsp;
            case (req_ff.func)
               FN_ADD: begin
                  if (match) begin
                     pend_in.status = STAT_DUPLICATE;
                     state_in       = S_EMIT;
                  end
               end
               FN_REMOVE: begin
                  if (match) begin
                     slot_in  = idx_ff[AW-1:0];
                     state_in = S_RDLAST;
                  end
               end
               FN_HEARTBEAT: begin
                  if (match) begin
                     ram.we              = 1'b1;
                     ram.wdata.last_seen = req_ff.now_us;
                     ram.wdata.missed    = 32'd0;
                     if (rd.state == ST_SUSPECTED) begin
                        ram.wdata.state = ST_ACTIVE;
                     end
                     state_in = S_EMIT;
                  end
               end
               FN_SET_STATE: begin
                  if (match) begin
                     ram.we          = 1'b1;
                     ram.wdata.state = req_ff.target_state;
                     state_in        = S_EMIT;
                  end
               end
               FN_LOOKUP: begin
                  if (match) begin
                     pend_in.found_id     = rd.id;
                     pend_in.peer_state   = rd.state;
                     pend_in.found_port   = rd.port;
                     pend_in.missed_count = rd.missed;
                     pend_in.last_seen_us = rd.last_seen;
                     pend_in.joined_us    = rd.joined;
                     state_in             = S_EMIT;
                  end
               end
               FN_SWEEP: begin
                  ram.we    = 1'b1;
                  ram.wdata = swept;
                  if (died) begin
                     tally_in = tally_ff + TALLY_W'(1);
                  end
               end
               FN_COUNT: begin
                  if (is_active) begin
                     tally_in = tally_ff + TALLY_W'(1);
                  end
               end
               FN_LIST: begin
                  if (is_active) begin
                     tally_in = tally_ff + TALLY_W'(1);
                     if (list2_ff) begin
                        pend_in.found_id = rd.id;
                        pend_in.tally    = n_ff;
                        pend_in.last     = (tally_ff + TALLY_W'(1) == n_ff);
                        state_in         = S_EMIT;
                     end
                  end
               end
               default: ;
            endcase
         end
         S_RDLAST: begin
            ram.raddr = cnt_dec[AW-1:0];
            state_in  = S_MOVE;
         end
         S_MOVE: begin
            ram.we    = 1'b1;
            ram.waddr = slot_ff;
            ram.wdata = rd;
            count_in  = cnt_dec;
            pend_in   = zero_rsp;
            state_in  = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_in       = pend_ff;
               rsp_valid_in = 1'b1;
               state_in     = pend_ff.last ? S_IDLE : S_RD;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      idx_ff     <= idx_in;
      slot_ff    <= slot_in;
      tally_ff   <= tally_in;
      n_ff       <= n_in;
      list2_ff   <= list2_in;
      hb_us_ff   <= hb_us_in;
      dead_us_ff <= dead_us_in;
      pend_ff    <= pend_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp        = rsp_ff;
   assign stat.count = count_ff;

endmodule

>>> src/peer_liveness_table.sv
// Peer liveness table: up to 64 peers kept packed in a single-port-read entry
// memory, one word per peer. Each item is handled alone: the block reads the
// table one entry at a time (read, then check and write back), and a search
// stops early at its match; a remove then reads the last entry and moves it
// into the freed slot, and an active list walks the table a second time when
// its first pass finds active peers. A result is held in an output register,
// so the next item is taken while it waits; an active list emits one result
// per listed id and waits on rsp_ready between them.
module peer_liveness_table (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_func,
   input  logic [31:0] req_peer_id,
   input  logic [15:0] req_peer_port,
   input  logic [2:0]  req_target_state,
   input  logic [63:0] req_now_us,
   input  logic [6:0]  req_list_limit,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_found_id,
   output logic [2:0]  rsp_peer_state,
   output logic [15:0] rsp_found_port,
   output logic [31:0] rsp_missed_count,
   output logic [63:0] rsp_last_seen_us,
   output logic [63:0] rsp_joined_us,
   output logic [6:0]  rsp_tally,
   output logic        rsp_last,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import plt_pkg::*;

   req_type       req;
   rsp_type       rsp;
   cfg_type       cfg;
   ram_req_type   ram;
   entry_type     rd;
   ctrl_stat_type stat;
   logic [ENTRY_W-1:0] rdata;

   assign req = '{func: func_type'(req_func), peer_id: req_peer_id,
                  peer_port: req_peer_port, target_state: req_target_state,
                  now_us: req_now_us, list_limit: req_list_limit};

   plt_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   plt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_PEERS),
      .AW    (AW)
   ) u_ram (
      .clock (clock),
      .we    (ram.we),
      .waddr (ram.waddr),
      .wdata (ram.wdata),
      .raddr (ram.raddr),
      .rdata (rdata)
   );

   assign rd = entry_type'(rdata);

   plt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req       (req),
      .cfg       (cfg),
      .ram       (ram),
      .rd        (rd),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp),
      .stat      (stat)
   );

   assign rsp_status       = rsp.status;
   assign rsp_found_id     = rsp.found_id;
   assign rsp_peer_state   = rsp.peer_state;
   assign rsp_found_port   = rsp.found_port;
   assign rsp_missed_count = rsp.missed_count;
   assign rsp_last_seen_us = rsp.last_seen_us;
   assign rsp_joined_us    = rsp.joined_us;
   assign rsp_tally        = rsp.tally;
   assign rsp_last         = rsp.last;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      stat.count <= CW'(MAX_PEERS))
      else $error("entry count beyond table depth");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item taken while engine busy");

   a_error_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STAT_OK |-> rsp_last)
      else $error("error result not final");

   a_tally_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_tally <= TALLY_W'(MAX_PEERS))
      else $error("tally beyond table depth");

endmodule

>>> bench/peer_liveness_table_checker.sv
module peer_liveness_table_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [2:0]  req_func,
   input  logic [31:0] req_peer_id,
   input  logic [15:0] req_peer_port,
   input  logic [2:0]  req_target_state,
   input  logic [63:0] req_now_us,
   input  logic [6:0]  req_list_limit,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [1:0]  rsp_status,
   input  logic [31:0] rsp_found_id,
   input  logic [2:0]  rsp_peer_state,
   input  logic [15:0] rsp_found_port,
   input  logic [31:0] rsp_missed_count,
   input  logic [63:0] rsp_last_seen_us,
   input  logic [63:0] rsp_joined_us,
   input  logic [6:0]  rsp_tally,
   input  logic        rsp_last,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   input  logic        pready,
   output int          fail_count,
   output int          pending,
   output int          result_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import plt_pkg::*;

   logic [31:0] hb_ms, dead_ms;
   logic [6:0]  cap;
   int          peer_count;
   logic [31:0] peer_ids [MAX_PEERS];
   peer_state_type peer_states [MAX_PEERS];
   logic [15:0] peer_ports [MAX_PEERS];
   logic [63:0] peer_seen [MAX_PEERS];
   logic [63:0] peer_joined [MAX_PEERS];
   logic [31:0] peer_missed [MAX_PEERS];
   rsp_type     expected_q [$];

   function automatic rsp_type blank(status_type st, logic [6:0] tally);
      rsp_type r;
      r = '0;
      r.status = st;
      r.tally = tally;
      r.last = 1'b1;
      return r;
   endfunction

   function automatic int find_peer(logic [31:0] id);
      for (int i = 0; i < peer_count; i++)
         if (peer_ids[i] == id) return i;
      return -1;
   endfunction

   task automatic predict_item();
      func_type    fn;
      int          slot, usable, n;
      logic [63:0] hb_us, dead_us, el;
      logic [31:0] listed [$];
      rsp_type     r;
      fn = func_type'(req_func);
      slot = find_peer(req_peer_id);
      usable = (cap > MAX_PEERS) ? MAX_PEERS : cap;
      case (fn)
         FN_ADD: begin
            if (slot >= 0) expected_q.push_back(blank(STAT_DUPLICATE, 0));
            else if (peer_count >= usable) expected_q.push_back(blank(STAT_FULL, 0));
            else begin
               peer_ids[peer_count] = req_peer_id;
               peer_states[peer_count] = ST_JOINING;
               peer_ports[peer_count] = req_peer_port;
               peer_seen[peer_count] = req_now_us;
               peer_joined[peer_count] = req_now_us;
               peer_missed[peer_count] = 0;
               peer_count++;
               expected_q.push_back(blank(STAT_OK, 0));
            end
         end
         FN_REMOVE, FN_HEARTBEAT, FN_SET_STATE, FN_LOOKUP: begin
            if (slot < 0) expected_q.push_back(blank(STAT_NOT_FOUND, 0));
            else begin
               r = blank(STAT_OK, 0);
               if (fn == FN_REMOVE) begin
                  peer_count--;
                  peer_ids[slot] = peer_ids[peer_count];
                  peer_states[slot] = peer_states[peer_count];
                  peer_ports[slot] = peer_ports[peer_count];
                  peer_seen[slot] = peer_seen[peer_count];
                  peer_joined[slot] = peer_joined[peer_count];
                  peer_missed[slot] = peer_missed[peer_count];
               end else if (fn == FN_HEARTBEAT) begin
                  peer_seen[slot] = req_now_us;
                  peer_missed[slot] = 0;
                  if (peer_states[slot] == ST_SUSPECTED) peer_states[slot] = ST_ACTIVE;
               end else if (fn == FN_SET_STATE) begin
                  peer_states[slot] = peer_state_type'(req_target_state);
               end else begin
                  r.found_id = peer_ids[slot];
                  r.peer_state = peer_states[slot];
                  r.found_port = peer_ports[slot];
                  r.missed_count = peer_missed[slot];
                  r.last_seen_us = peer_seen[slot];
                  r.joined_us = peer_joined[slot];
               end
               expected_q.push_back(r);
            end
         end
         FN_SWEEP: begin
            hb_us = 64'(hb_ms) * 64'd1000;
            dead_us = 64'(dead_ms) * 64'd1000;
            n = 0;
            for (int i = 0; i < peer_count; i++) begin
               el = (req_now_us > peer_seen[i]) ? req_now_us - peer_seen[i] : 64'd0;
               if (peer_states[i] == ST_ACTIVE && el > hb_us) begin
                  if (peer_missed[i] != 32'hFFFF_FFFF) peer_missed[i]++;
                  peer_states[i] = ST_SUSPECTED;
               end
               if ((peer_states[i] == ST_SUSPECTED || peer_states[i] == ST_JOINING)
                   && el > dead_us) begin
                  peer_states[i] = ST_DEAD;
                  n++;
               end
            end
            expected_q.push_back(blank(STAT_OK, 7'(n)));
         end
         FN_COUNT: begin
            n = 0;
            for (int i = 0; i < peer_count; i++)
               if (peer_states[i] == ST_ACTIVE) n++;
            expected_q.push_back(blank(STAT_OK, 7'(n)));
         end
         default: begin
            for (int i = 0; i < peer_count && listed.size() < req_list_limit; i++)
               if (peer_states[i] == ST_ACTIVE) listed.push_back(peer_ids[i]);
            if (listed.size() == 0) expected_q.push_back(blank(STAT_OK, 0));
            foreach (listed[k]) begin
               r = blank(STAT_OK, 7'(listed.size()));
               r.found_id = listed[k];
               r.last = (k == listed.size() - 1);
               expected_q.push_back(r);
            end
         end
      endcase
   endtask

   task automatic check_field(string name, logic [63:0] want, logic [63:0] got,
                              inout bit bad);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         bad = 1;
      end
   endtask

   task automatic check_result();
      rsp_type e;
      bit      bad;
      bad = 0;
      result_count++;
      if (expected_q.size() == 0) begin
         $error("result with no item outstanding: id %0h", rsp_found_id);
         fail_count++;
         return;
      end
      e = expected_q.pop_front();
      check_field("status", e.status, rsp_status, bad);
      check_field("found_id", e.found_id, rsp_found_id, bad);
      check_field("peer_state", e.peer_state, rsp_peer_state, bad);
      check_field("found_port", e.found_port, rsp_found_port, bad);
      check_field("missed_count", e.missed_count, rsp_missed_count, bad);
      check_field("last_seen_us", e.last_seen_us, rsp_last_seen_us, bad);
      check_field("joined_us", e.joined_us, rsp_joined_us, bad);
      check_field("tally", e.tally, rsp_tally, bad);
      check_field("last", e.last, rsp_last, bad);
      if (bad) fail_count++;
   endtask

   initial begin
      fail_count = 0;
      pending = 0;
      result_count = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         hb_ms = 32'd1000;
         dead_ms = 32'd5000;
         cap = 7'd64;
         peer_count = 0;
         expected_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) check_result();
         if (req_valid && req_ready) predict_item();
         if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
               REG_HB_TIMEOUT:   hb_ms = pwdata;
               REG_DEAD_TIMEOUT: dead_ms = pwdata;
               REG_CAPACITY:     cap = pwdata[6:0];
               default: ;
            endcase
         end
      end
      pending = expected_q.size();
   end

endmodule

>>> bench/peer_liveness_table_tb.sv
module peer_liveness_table_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import plt_pkg::*;

   localparam int IDLE_LIMIT = 5000;

   logic        clock, reset;
   logic        req_valid, req_ready;
   logic [2:0]  req_func;
   logic [31:0] req_peer_id;
   logic [15:0] req_peer_port;
   logic [2:0]  req_target_state;
   logic [63:0] req_now_us;
   logic [6:0]  req_list_limit;
   logic        rsp_valid, rsp_ready;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_found_id;
   logic [2:0]  rsp_peer_state;
   logic [15:0] rsp_found_port;
   logic [31:0] rsp_missed_count;
   logic [63:0] rsp_last_seen_us, rsp_joined_us;
   logic [6:0]  rsp_tally;
   logic        rsp_last;
   logic        psel, penable, pwrite, pready;
   logic [3:0]  paddr;
   logic [31:0] pwdata, prdata;

   int          fail_count, pending, result_count;
   int          item_count, setting_count, quiet_cycles;
   bit          no_idle;
   logic [63:0] sim_now;
   logic [31:0] id_pool [8];
   int          stall_left;

   peer_liveness_table dut (.*);

   peer_liveness_table_checker chk (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || stall_left == 0) begin
         if (!no_idle && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            stall_left <= ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3)
                                                      : $urandom_range(10, 40);
         end else
            rsp_ready <= 1'b1;
      end else begin
         stall_left <= stall_left - 1;
         if (stall_left == 1) rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
         $display("peer_liveness_table_tb NOT OK");
         $finish;
      end
   end

   task automatic send(func_type fn, logic [31:0] id, logic [15:0] port,
                       logic [2:0] tstate, logic [63:0] now, logic [6:0] limit);
      int gap;
      gap = 0;
      if (!no_idle) begin
         gap = $urandom_range(0, 9);
         gap = (gap < 6) ? 0 : (gap < 9) ? $urandom_range(1, 3) : $urandom_range(10, 50);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= fn;
      req_peer_id <= id;
      req_peer_port <= port;
      req_target_state <= tstate;
      req_now_us <= now;
      req_list_limit <= limit;
      do @(posedge clock); while (!req_ready);
      item_count++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic random_item();
      int          pick;
      logic [31:0] id;
      func_type    fn;
      logic [2:0]  ts;
      pick = $urandom_range(0, 99);
      fn = (pick < 25) ? FN_ADD : (pick < 35) ? FN_REMOVE : (pick < 50) ? FN_HEARTBEAT :
           (pick < 65) ? FN_SET_STATE : (pick < 75) ? FN_SWEEP : (pick < 85) ? FN_LOOKUP :
           (pick < 90) ? FN_COUNT : FN_LIST;
      id = ($urandom_range(0, 9) < 8) ? id_pool[$urandom_range(0, 7)] : $urandom;
      ts = ($urandom_range(0, 1) == 0) ? ST_ACTIVE : 3'($urandom_range(0, 7));
      pick = $urandom_range(0, 19);
      if (pick == 0) sim_now = sim_now - 64'($urandom_range(0, 5_000_000));
      else if (pick == 1) sim_now = {$urandom, $urandom};
      else sim_now = sim_now + 64'($urandom_range(0, 3_000_000));
      send(fn, id, 16'($urandom), ts, sim_now, 7'($urandom_range(0, 64)));
   endtask

   task automatic run_phase(logic [31:0] hb, logic [31:0] dead, logic [6:0] cap_val,
                            int n);
      write_reg(REG_HB_TIMEOUT, hb);
      write_reg(REG_DEAD_TIMEOUT, dead);
      write_reg(REG_CAPACITY, {25'd0, cap_val});
      setting_count++;
      no_idle = ($urandom_range(0, 2) == 0);
      for (int i = 0; i < n; i++) begin
         if (i == n / 2) begin
            wait_drained();
            no_idle = !no_idle;
         end
         random_item();
      end
      wait_drained();
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_func = FN_ADD;
      req_peer_id = '0;
      req_peer_port = '0;
      req_target_state = '0;
      req_now_us = '0;
      req_list_limit = '0;
      rsp_ready = 1'b0;
      stall_left = 0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      quiet_cycles = 0;
      item_count = 0;
      setting_count = 1;
      no_idle = 1'b0;
      sim_now = 64'd1_000_000;
      foreach (id_pool[i]) id_pool[i] = $urandom;
      id_pool[0] = 32'h0;
      id_pool[1] = 32'hFFFF_FFFF;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed, default settings
      send(FN_ADD, 32'h0, 16'h0, ST_UNKNOWN, 64'h0, 7'd0);
      send(FN_ADD, 32'hFFFF_FFFF, 16'hFFFF, ST_UNKNOWN, '1, 7'd0);
      send(FN_ADD, 32'h0, 16'h1234, ST_UNKNOWN, 64'd5, 7'd0);
      send(FN_LOOKUP, 32'h0, 16'h0, ST_UNKNOWN, 64'd0, 7'd0);
      send(FN_LOOKUP, 32'hFFFF_FFFF, 16'h0, ST_UNKNOWN, 64'd0, 7'd0);
      send(FN_LOOKUP, 32'h5, 16'h0, ST_UNKNOWN, 64'd0, 7'd0);
      send(FN_HEARTBEAT, 32'h5, 16'h0, ST_UNKNOWN, 64'd9, 7'd0);
      send(FN_SET_STATE, 32'h5, 16'h0, ST_DEAD, 64'd0, 7'd0);
      send(FN_REMOVE, 32'h5, 16'h0, ST_UNKNOWN, 64'd0, 7'd0);
      send(FN_SET_STATE, 32'hFFFF_FFFF, 16'h0, ST_ACTIVE, 64'd0, 7'd0);
      send(FN_SET_STATE, 32'h0, 16'h0, ST_SUSPECTED, 64'd0, 7'd0);
      send(FN_HEARTBEAT, 32'h0, 16'h0, ST_UNKNOWN, 64'd123, 7'd0);
      send(FN_COUNT, 32'h0, 16'h0, ST_UNKNOWN, 64'd0, 7'd0);
      send(FN_LIST, 32'h0, 16'h0, ST_UNKNOWN, 64'd0, 7'd64);
      send(FN_LIST, 32'h0, 16'h0, ST_UNKNOWN, 64'd0, 7'd0);
      send(FN_LIST, 32'h0, 16'h0, ST_UNKNOWN, 64'd0, 7'd1);
      send(FN_SWEEP, 32'h0, 16'h0, ST_UNKNOWN, 64'd0, 7'd0);
      send(FN_SWEEP, 32'h0, 16'h0, ST_UNKNOWN, 64'h7FFF_FFFF_FFFF_FFFF, 7'd63);
      send(FN_LOOKUP, 32'h0, 16'h0, ST_UNKNOWN, 64'd0, 7'd0);
      send(FN_SET_STATE, 32'h0, 16'h0, ST_BYZANTINE, 64'd0, 7'd0);
      send(FN_REMOVE, 32'h0, 16'h0, ST_UNKNOWN, 64'd0, 7'd0);
      send(FN_LOOKUP, 32'hFFFF_FFFF, 16'h0, ST_UNKNOWN, 64'd0, 7'd0);
      send(FN_REMOVE, 32'hFFFF_FFFF, 16'h0, ST_UNKNOWN, 64'd0, 7'd0);
      wait_drained();

      run_phase(32'd0, 32'd0, 7'd1, 25);
      run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'd127, 30);
      run_phase(32'd1, 32'd3, 7'd4, 25);
      run_phase(32'd2, 32'd10, 7'd0, 15);
      run_phase(32'd1000, 32'd5000, 7'd64, 30);
      run_phase($urandom_range(0, 3000), $urandom_range(0, 8000), 7'd64, 30);

      $display("sent %0d items over %0d register settings, checked %0d results",
               item_count, setting_count, result_count);
      if (fail_count == 0) begin
         $display("peer_liveness_table_tb OK");
      end else begin
         $display("peer_liveness_table_tb NOT OK");
      end
      $finish;
   end

endmodule

>>> sim.f
src/plt_pkg.sv
src/plt_ram.sv
src/plt_csr.sv
src/plt_ctrl.sv
src/peer_liveness_table.sv
bench/peer_liveness_table_checker.sv
bench/peer_liveness_table_tb.sv
